@@ sv/swm_pkg.sv @@
// shared constants for the sliding window maximum block
package swm_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WIN_SIZE_RST = CFG_W'(1);

endpackage

@@ sv/swm_ram.sv @@
// single port write, single port read memory with registered read data
module swm_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 40,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/swm_ctrl.sv @@
// deque sequencer: head age check, tail pops, append and head read-back
module swm_ctrl
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned IDX_W      = $clog2(WINDOW_MAX),
  parameter int unsigned POS_W      = $clog2(4 * WINDOW_MAX)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [DATA_WIDTH-1:0]       in_sample_i,
  input  logic                        in_sos_i,
  input  logic                        in_eos_i,
  input  logic [CFG_W-1:0]            win_size_i,
  input  logic                        res_free_i,
  output logic                        res_valid_o,
  output logic [DATA_WIDTH-1:0]       res_max_o,
  output logic                        res_last_o,
  output logic                        mem_we_o,
  output logic [IDX_W-1:0]            mem_waddr_o,
  output logic [POS_W+DATA_WIDTH-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]            mem_raddr_o,
  input  logic [POS_W+DATA_WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W  = IDX_W + 1;
  localparam int unsigned K_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned CMP_W  = (POS_W + 1 > K_W) ? POS_W + 1 : K_W;
  localparam int unsigned POS_SPAN = 4 * WINDOW_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TAIL,
    ST_APPEND,
    ST_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    filled_q, filled_d;
  logic                    fwd_q, fwd_d;
  logic [DATA_WIDTH-1:0]   smp_q, smp_d;
  logic                    eos_q, eos_d;

  logic [K_W-1:0]          win_k;
  logic [DATA_WIDTH-1:0]   rd_val;
  logic [POS_W-1:0]        rd_pos;
  logic [POS_W-1:0]        rd_age;
  logic [POS_W:0]          pos_inc;
  logic [IDX_W-1:0]        app_head;
  logic [CNT_W-1:0]        app_count;
  logic [CNT_W-1:0]        hd_count;
  logic [IDX_W-1:0]        hd_head;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, h} + SUM_W'(off);
    if (sum >= SUM_W'(WINDOW_MAX)) begin
      sum = sum - SUM_W'(WINDOW_MAX);
    end
    return sum[IDX_W-1:0];
  endfunction

  // window length clamped to 1..WINDOW_MAX
  always_comb begin
    if (win_size_i == '0) begin
      win_k = K_W'(1);
    end else if (K_W'(win_size_i) > K_W'(WINDOW_MAX)) begin
      win_k = K_W'(WINDOW_MAX);
    end else begin
      win_k = K_W'(win_size_i);
    end
  end

  assign rd_val  = mem_rdata_i[DATA_WIDTH-1:0];
  assign rd_pos  = mem_rdata_i[DATA_WIDTH +: POS_W];
  assign pos_inc = {1'b0, pos_q} + (POS_W + 1)'(1);

  // wrap-aware age of the entry just read
  always_comb begin
    logic [POS_W:0] wide;
    if (pos_q >= rd_pos) begin
      wide = {1'b0, pos_q} - {1'b0, rd_pos};
    end else begin
      wide = {1'b0, pos_q} + (POS_W + 1)'(POS_SPAN) - {1'b0, rd_pos};
    end
    rd_age = wide[POS_W-1:0];
  end

  // head drop for a full deque on append
  always_comb begin
    if (count_q == CNT_W'(WINDOW_MAX)) begin
      app_head  = slot(head_q, CNT_W'(1));
      app_count = count_q - CNT_W'(1);
    end else begin
      app_head  = head_q;
      app_count = count_q;
    end
  end

  // head drop for an aged-out head
  always_comb begin
    if (count_q != '0 && CMP_W'(rd_age) >= CMP_W'(win_k)) begin
      hd_head  = slot(head_q, CNT_W'(1));
      hd_count = count_q - CNT_W'(1);
    end else begin
      hd_head  = head_q;
      hd_count = count_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    filled_d    = filled_q;
    fwd_d       = fwd_q;
    smp_d       = smp_q;
    eos_d       = eos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = app_head;
    mem_wdata_o = {pos_q, smp_q};
    mem_raddr_o = head_q;
    res_valid_o = 1'b0;
    res_max_o   = fwd_q ? smp_q : rd_val;
    res_last_o  = eos_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          smp_d   = in_sample_i;
          eos_d   = in_eos_i;
          state_d = ST_HEAD;
          if (in_sos_i) begin
            head_d   = '0;
            count_d  = '0;
            pos_d    = '0;
            filled_d = 1'b0;
          end
        end
      end
      ST_HEAD: begin
        head_d  = hd_head;
        count_d = hd_count;
        if (hd_count != '0) begin
          mem_raddr_o = slot(hd_head, hd_count - CNT_W'(1));
          state_d     = ST_TAIL;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_TAIL: begin
        if ($signed(rd_val) <= $signed(smp_q)) begin
          count_d = count_q - CNT_W'(1);
          if (count_q != CNT_W'(1)) begin
            mem_raddr_o = slot(head_q, count_q - CNT_W'(2));
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(app_head, app_count);
        head_d      = app_head;
        count_d     = app_count + CNT_W'(1);
        mem_raddr_o = app_head;
        fwd_d       = (app_count == '0);
        if (CMP_W'(pos_inc) >= CMP_W'(win_k)) begin
          filled_d = 1'b1;
        end
        if (pos_inc == (POS_W + 1)'(POS_SPAN)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_inc[POS_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!filled_q) begin
          state_d = ST_IDLE;
        end else if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      filled_q <= filled_d;
      fwd_q    <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    eos_q <= eos_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_MAX))
    else $error("deque count above capacity");

  a_head_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD) |-> $past(state_q == ST_IDLE && in_valid_i))
    else $error("head check without an accepted item");

  a_tail_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) |-> (count_q != '0))
    else $error("tail pop on empty deque");

  a_append_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPEND) |=> (count_q != '0 && state_q == ST_OUT))
    else $error("append left deque empty");

  a_result_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (filled_q && res_free_i))
    else $error("result before window filled");
`endif

endmodule

@@ sv/sliding_window_maximum.sv @@
// Streaming maximum over the last window_size samples, kept as a monotonic
// deque of (value, position) entries in one synchronous memory. An item
// passes through these steps in order: acceptance, the head read, the
// tail reads, the append and the hand-over of the result to the output
// register. The tail reads cover every tail entry popped and, when an
// entry is left in the deque after the head check and the pops, that
// entry too. The result sits in an output register, so the next item is
// taken while it waits; a result that finds the output register still
// full holds the block in its hand-over step. No result appears until
// window_size samples of the current sequence have arrived; a window_size
// of zero acts as one and values above WINDOW_MAX act as WINDOW_MAX. Write
// the window size only while the block is idle.
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i,     // window_size
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // sample
  input  logic               s_axis_tuser,   // start_of_sequence
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // window_max
  output logic               m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(WINDOW_MAX);
  localparam int unsigned POS_W = $clog2(4 * WINDOW_MAX);
  localparam int unsigned ENT_W = POS_W + DATA_WIDTH;

  logic [CFG_W-1:0]      win_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_max_q;
  logic                  out_last_q;
  logic                  res_free;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_max;
  logic                  res_last;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENT_W-1:0]      mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_SIZE_RST;
    end else if (cfg_valid_i) begin
      win_q <= cfg_data_i;
    end
  end

  // output register
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_max_q  <= res_max;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_max_q);
  assign m_axis_tlast  = out_last_q;

  swm_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W),
    .POS_W      (POS_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[DATA_WIDTH-1:0]),
    .in_sos_i    (s_axis_tuser),
    .in_eos_i    (s_axis_tlast),
    .win_size_i  (win_q),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_max_o   (res_max),
    .res_last_o  (res_last),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  swm_ram #(
    .DEPTH  (WINDOW_MAX),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ tb/testbench.sv @@
// self-checking stream testbench for the sliding window maximum block
module testbench;
  import swm_pkg::*;

  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam int unsigned TDATA_W = ((DW + 7) / 8) * 8;
  localparam int unsigned WIN_MAX = WINDOW_MAX_DEF;
  localparam int unsigned POS_SPAN = 4 * WINDOW_MAX_DEF;
  localparam int unsigned SETTLE_CYCLES = WINDOW_MAX_DEF + 40;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] sample;
    logic                 sos;
    logic                 eos;
  } sample_item_t;

  typedef struct packed {
    logic [DW-1:0] max_val;
    logic          last;
  } max_result_t;

  typedef enum int {SEQ_RANDOM, SEQ_NARROW, SEQ_FALLING, SEQ_RISING, SEQ_EXTREME} seq_kind_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;    // sample
  logic               s_axis_tuser = 1'b0;  // start_of_sequence
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;         // window_max
  logic               m_axis_tlast;

  sample_item_t pending_items[$];
  max_result_t  expected_max[$];

  logic signed [DW-1:0] peak_val [WIN_MAX];
  int unsigned          peak_pos [WIN_MAX];
  int unsigned          peak_len = 0;
  int unsigned          peak_first = 0;
  int unsigned          seq_pos = 0;
  bit                   win_full = 1'b0;
  logic [CFG_W-1:0]     win_setting = WIN_SIZE_RST;

  bit          send_idling = 1'b1;
  bit          recv_idling = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  sliding_window_maximum uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned effective_span(input logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > WIN_MAX) return WIN_MAX;
    return 32'(setting);
  endfunction

  // advances the window state by one sample, returns 1 when a maximum is due
  function automatic bit advance_window(input logic signed [DW-1:0] smp, input logic sos,
                                        output logic signed [DW-1:0] win_max);
    int unsigned span;
    int unsigned age;
    int unsigned slot;
    span = effective_span(win_setting);
    if (sos) begin
      peak_len = 0;
      peak_first = 0;
      seq_pos = 0;
      win_full = 1'b0;
    end
    if (peak_len > 0) begin
      age = (seq_pos + POS_SPAN - peak_pos[peak_first]) % POS_SPAN;
      if (age >= span) begin
        peak_first = (peak_first + 1) % WIN_MAX;
        peak_len--;
      end
    end
    while (peak_len > 0 && peak_val[(peak_first + peak_len - 1) % WIN_MAX] <= smp)
      peak_len--;
    if (peak_len >= WIN_MAX) begin
      peak_first = (peak_first + 1) % WIN_MAX;
      peak_len--;
    end
    slot = (peak_first + peak_len) % WIN_MAX;
    peak_val[slot] = smp;
    peak_pos[slot] = seq_pos;
    peak_len++;
    if (seq_pos + 1 >= span) win_full = 1'b1;
    seq_pos = (seq_pos + 1) % POS_SPAN;
    win_max = peak_val[peak_first];
    return win_full;
  endfunction

  function automatic void push_item(input logic signed [DW-1:0] smp, input logic sos,
                                    input logic eos);
    sample_item_t it;
    it = '{smp, sos, eos};
    pending_items.insert(pending_items.size(), it);
  endfunction

  // random sequences with random content, some without a start flag
  task automatic load_items(input logic [CFG_W-1:0] setting, input int unsigned total,
                            input bit carry_on, input bit no_starts);
    int unsigned span;
    int unsigned n;
    int unsigned len;
    int unsigned i;
    bit first;
    bit open_seq;
    seq_kind_e kind;
    logic signed [DW-1:0] v;
    span = effective_span(setting);
    n = 0;
    first = 1'b1;
    while (n < total) begin
      len = $urandom_range(1, 2 * span + 8);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 3);
      kind = seq_kind_e'($urandom_range(0, 4));
      open_seq = no_starts || (first && carry_on) || $urandom_range(0, 7) == 0;
      v = DW'($urandom);
      for (i = 0; i < len; i++) begin
        case (kind)
          SEQ_RANDOM: v = DW'($urandom);
          SEQ_NARROW: v = DW'(int'($urandom_range(0, 6)) - 3);
          SEQ_FALLING: v = v - DW'($urandom_range(0, 3));
          SEQ_RISING: v = v + DW'($urandom_range(0, 3));
          default: begin
            case ($urandom_range(0, 4))
              0: v = MAX_VAL;
              1: v = MIN_VAL;
              2: v = '0;
              3: v = '1;
              default: v = DW'(1);
            endcase
          end
        endcase
        push_item(v, (i == 0) && !open_seq, (i == len - 1) || $urandom_range(0, 31) == 0);
      end
      first = 1'b0;
      n += len;
    end
  endtask

  // waits until the block has taken every item and returned every result
  task automatic settle();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_max.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] size);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_setting = size;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : drive_samples
    logic signed [DW-1:0] mx;
    sample_item_t nxt;
    max_result_t due;
    logic give;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (advance_window(s_axis_tdata[DW-1:0], s_axis_tuser, mx)) begin
          due = '{mx, s_axis_tlast};
          expected_max.insert(expected_max.size(), due);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        give = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (send_idling && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 15) - 1;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items[0];
          pending_items.delete(0);
          give = 1'b1;
          s_axis_tdata <= TDATA_W'(nxt.sample);
          s_axis_tuser <= nxt.sos;
          s_axis_tlast <= nxt.eos;
        end
        s_axis_tvalid <= give;
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (recv_idling && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    max_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_max.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: window_max %0d last %0b",
                   $signed(m_axis_tdata[DW-1:0]), m_axis_tlast);
      end else begin
        want = expected_max[0];
        expected_max.delete(0);
        if (m_axis_tdata[DW-1:0] !== want.max_val || m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected window_max %0d last %0b, got window_max %0d last %0b",
                     $signed(want.max_val), want.last,
                     $signed(m_axis_tdata[DW-1:0]), m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sliding_window_maximum regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned wsize;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window of one
    push_item(MAX_VAL, 1'b1, 1'b0);
    push_item(MIN_VAL, 1'b0, 1'b1);
    push_item('0, 1'b1, 1'b1);
    settle();

    set_window(CFG_W'(3));
    push_item(MAX_VAL, 1'b1, 1'b0);
    push_item(MIN_VAL, 1'b0, 1'b0);
    push_item('0, 1'b0, 1'b0);
    push_item('1, 1'b0, 1'b0);
    push_item('1, 1'b0, 1'b0);
    push_item('1, 1'b0, 1'b1);
    // equal values pop the tail
    push_item(5, 1'b0, 1'b0);
    push_item(5, 1'b0, 1'b0);
    push_item(5, 1'b0, 1'b1);
    // restart in the middle of a sequence
    push_item(10, 1'b1, 1'b0);
    push_item(20, 1'b0, 1'b0);
    push_item(30, 1'b0, 1'b1);
    // head leaves the window
    push_item(100, 1'b1, 1'b0);
    push_item(90, 1'b0, 1'b0);
    push_item(80, 1'b0, 1'b0);
    push_item(70, 1'b0, 1'b1);
    // sequence shorter than the window
    push_item(MIN_VAL, 1'b1, 1'b1);
    settle();

    // zero acts as one
    set_window(CFG_W'(0));
    load_items(CFG_W'(0), 120, 1'b0, 1'b0);
    settle();

    send_idling = 1'b0;
    recv_idling = 1'b0;
    set_window(CFG_W'(1));
    load_items(CFG_W'(1), 100, 1'b1, 1'b0);
    settle();

    send_idling = 1'b1;
    recv_idling = 1'b1;
    set_window(CFG_W'(64));
    load_items(CFG_W'(64), 160, 1'b0, 1'b0);
    settle();

    // above the maximum saturates, sequence carries on
    set_window(CFG_W'(127));
    load_items(CFG_W'(127), 120, 1'b1, 1'b0);
    settle();

    // one long sequence so positions wrap
    set_window(CFG_W'(64));
    load_items(CFG_W'(64), 300, 1'b0, 1'b1);
    settle();

    // shrink while a sequence is open
    set_window(CFG_W'(2));
    load_items(CFG_W'(2), 100, 1'b1, 1'b0);
    settle();

    set_window(CFG_W'(7));
    load_items(CFG_W'(7), 60, 1'b0, 1'b0);
    settle();
    load_items(CFG_W'(7), 60, 1'b1, 1'b0);
    settle();

    wsize = $urandom_range(8, 63);
    set_window(CFG_W'(wsize));
    load_items(CFG_W'(wsize), 120, 1'b0, 1'b0);
    settle();

    wsize = $urandom_range(65, 126);
    set_window(CFG_W'(wsize));
    load_items(CFG_W'(wsize), 100, 1'b1, 1'b0);
    settle();

    send_idling = 1'b0;
    recv_idling = 1'b0;
    set_window(CFG_W'(5));
    load_items(CFG_W'(5), 120, 1'b0, 1'b0);
    settle();

    if (mismatch_count == 0 && expected_max.size() == 0) begin
      $display("sliding_window_maximum regression: pass");
    end else begin
      $display("sliding_window_maximum regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/swm_pkg.sv
sv/swm_ram.sv
sv/swm_ctrl.sv
sv/sliding_window_maximum.sv
tb/testbench.sv
